@@ design/assert_macros.svh @@
// assertion macros used by stable_priority_queue
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, expr, msg)
`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ design/spq_pkg.sv @@
// shared constants and types of the stable priority queue
// no dependencies
package spq_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int KEY_WIDTH_DEF  = 16;
  localparam int PRIO_WIDTH_DEF = 8;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  // request operations
  localparam op_t OP_ADD    = 2'd0;
  localparam op_t OP_REMOVE = 2'd1;
  localparam op_t OP_UPDATE = 2'd2;
  localparam op_t OP_SERVE  = 2'd3;

  // result status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;
  localparam status_t ST_FULL     = 2'd3;

  // command broadcast to every cell of the row
  typedef logic [2:0] cell_op_t;
  localparam cell_op_t CELL_HOLD = 3'd0;
  localparam cell_op_t CELL_SCAN = 3'd1;
  localparam cell_op_t CELL_POP  = 3'd2;
  localparam cell_op_t CELL_DEL  = 3'd3;
  localparam cell_op_t CELL_INS  = 3'd4;

  // control bits handed from one cell to its right neighbour
  typedef struct packed {
    logic valid;
    logic stay;
    logic tok;
    logic tokf;
  } link_t;

endpackage

@@ design/spq_if.sv @@
// request and result channel interfaces of the stable priority queue
// depends on spq_pkg
interface spq_req_if #(
  parameter int KEY_WIDTH      = spq_pkg::KEY_WIDTH_DEF,
  parameter int PRIORITY_WIDTH = spq_pkg::PRIO_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::OP_W-1:0]      op;
  logic [KEY_WIDTH-1:0]          key;
  logic [PRIORITY_WIDTH-1:0]     priority_req;

  modport source (output valid, op, key, priority_req, input ready);
  modport sink   (input valid, op, key, priority_req, output ready);
endinterface

interface spq_rsp_if #(
  parameter int KEY_WIDTH      = spq_pkg::KEY_WIDTH_DEF,
  parameter int PRIORITY_WIDTH = spq_pkg::PRIO_WIDTH_DEF,
  parameter int OCC_WIDTH      = $clog2(spq_pkg::CAPACITY_DEF + 1)
);
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::STATUS_W-1:0]  status;
  logic [KEY_WIDTH-1:0]          served_key;
  logic [PRIORITY_WIDTH-1:0]     served_priority;
  logic [OCC_WIDTH-1:0]          occupancy;

  modport source (output valid, status, served_key, served_priority, occupancy, input ready);
  modport sink   (input valid, status, served_key, served_priority, occupancy, output ready);
endinterface

@@ design/stable_priority_queue.sv @@
// stable priority queue: request and result channels over a row of sorting cells
// depends on spq_pkg, spq_if, spq_cell and assert_macros.svh
//
// usage
// - req carries op, key and priority_req; rsp returns status, served_key,
//   served_priority and occupancy, one result for every request
// - entries sit in a row of CAPACITY cells in ascending priority order,
//   equal priorities in arrival order; cell 0 is the front
// - add: insert in one row-wide shift (S_INS), then the result (S_DONE)
// - serve: front is read, the row shifts left once (S_POP), then S_DONE
// - remove and update: the match token walks the row one cell a cycle
//   (S_SCAN) to find the first equal key, which S_CHK deletes; update then inserts
// - remove and serve on an empty queue skip the walk and the shift; update
//   on an empty queue skips the walk and goes straight to the insert
// - one request is in work at a time; req.ready is high only while idle, so the
//   next request is taken once the previous one has finished
// - a finished result waits in the rsp register; a new request is still
//   taken while it waits, and its result holds until rsp is drained
// - rst (synchronous, active high) empties the queue and drops any
//   pending result; the row needs no clearing pass
`include "assert_macros.svh"

module stable_priority_queue #(
  parameter int CAPACITY       = spq_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH      = spq_pkg::KEY_WIDTH_DEF,
  parameter int PRIORITY_WIDTH = spq_pkg::PRIO_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  spq_req_if.sink   req,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);   // occupancy width
  localparam int IW = $clog2(CAPACITY);       // walk step counter width

  // controller states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_INS  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic [IW-1:0] scnt;
  logic          rsp_valid;

  // request being worked on
  op_t                       cur_op;
  logic [KEY_WIDTH-1:0]      cur_key;
  logic [PRIORITY_WIDTH-1:0] cur_prio;
  status_t                   status;
  logic [KEY_WIDTH-1:0]      served_key;
  logic [PRIORITY_WIDTH-1:0] served_prio;

  // result register
  status_t                   rsp_status;
  logic [KEY_WIDTH-1:0]      rsp_key;
  logic [PRIORITY_WIDTH-1:0] rsp_prio;
  logic [CW-1:0]             rsp_occ;

  // row of cells
  link_t                     links [CAPACITY];
  logic [KEY_WIDTH-1:0]      keys  [CAPACITY];
  logic [PRIORITY_WIDTH-1:0] prios [CAPACITY];
  logic [CAPACITY-1:0]       valid_vec;
  link_t                     head;
  cell_op_t                  cell_op;
  logic                      found;
  logic                      full;
  logic                      req_take;
  logic                      rsp_free;

  assign req.ready = (state == S_IDLE);
  assign req_take  = req.valid && req.ready;
  assign rsp_free  = !rsp_valid || rsp.ready;
  assign full      = (count == CW'(CAPACITY));
  // the token has left the last cell carrying whether any cell matched
  assign found     = links[CAPACITY-1].tokf;

  // cell 0 sees an empty left neighbour that always keeps its place
  assign head.valid = 1'b0;
  assign head.stay  = 1'b1;
  assign head.tok   = (state == S_SCAN) && (scnt == '0);
  assign head.tokf  = 1'b0;

  always_comb begin
    unique case (state)
      S_SCAN:  cell_op = CELL_SCAN;
      S_CHK:   cell_op = found ? CELL_DEL : CELL_HOLD;
      S_POP:   cell_op = CELL_POP;
      S_INS:   cell_op = full ? CELL_HOLD : CELL_INS;
      default: cell_op = CELL_HOLD;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    link_t                     l_link;
    logic [KEY_WIDTH-1:0]      l_key;
    logic [PRIORITY_WIDTH-1:0] l_prio;
    logic                      r_valid;
    logic [KEY_WIDTH-1:0]      r_key;
    logic [PRIORITY_WIDTH-1:0] r_prio;

    if (i == 0) begin : g_first
      assign l_link = head;
      assign l_key  = '0;
      assign l_prio = '0;
    end else begin : g_inner_l
      assign l_link = links[i-1];
      assign l_key  = keys[i-1];
      assign l_prio = prios[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_key   = '0;
      assign r_prio  = '0;
    end else begin : g_inner_r
      assign r_valid = links[i+1].valid;
      assign r_key   = keys[i+1];
      assign r_prio  = prios[i+1];
    end

    spq_cell #(
      .KEY_WIDTH      (KEY_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (cell_op),
      .new_key     (cur_key),
      .new_prio    (cur_prio),
      .left        (l_link),
      .left_key    (l_key),
      .left_prio   (l_prio),
      .right_valid (r_valid),
      .right_key   (r_key),
      .right_prio  (r_prio),
      .link        (links[i]),
      .key         (keys[i]),
      .prio        (prios[i])
    );

    assign valid_vec[i] = links[i].valid;
  end

  // control: state, occupancy, walk counter, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      scnt      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // a finished result loads the rsp register, else a taken one empties it
      if ((state == S_DONE) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_take) begin
            scnt <= '0;
            unique case (req.op) inside
              OP_ADD: state <= S_INS;
              OP_REMOVE, OP_UPDATE: begin
                if (count == '0) begin
                  state <= (req.op == OP_UPDATE) ? S_INS : S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: state <= (count == '0) ? S_DONE : S_POP;
            endcase
          end
        end
        S_SCAN: begin
          scnt <= scnt + IW'(1);
          if (scnt == IW'(CAPACITY - 1)) state <= S_CHK;
        end
        S_CHK: begin
          if (found) count <= count - CW'(1);
          state <= (cur_op == OP_UPDATE) ? S_INS : S_DONE;
        end
        S_POP: begin
          count <= count - CW'(1);
          state <= S_DONE;
        end
        S_INS: begin
          if (!full) count <= count + CW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request payload, status and result fields
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_take) begin
          cur_op      <= req.op;
          cur_key     <= req.key;
          cur_prio    <= req.priority_req;
          served_key  <= '0;
          served_prio <= '0;
          // empty queue answers remove, update and serve with its own code
          status <= ((req.op != OP_ADD) && (count == '0)) ? ST_EMPTY : ST_OK;
        end
      end
      S_CHK: begin
        if (!found) status <= ST_NOTFOUND;
      end
      S_POP: begin
        served_key  <= keys[0];
        served_prio <= prios[0];
      end
      S_INS: begin
        if (full) status <= ST_FULL;
      end
      S_DONE: begin
        if (rsp_free) begin
          rsp_status <= status;
          rsp_key    <= served_key;
          rsp_prio   <= served_prio;
          rsp_occ    <= count;
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.status          = rsp_status;
  assign rsp.served_key      = rsp_key;
  assign rsp.served_priority = rsp_prio;
  assign rsp.occupancy       = rsp_occ;

  // occupancy never passes the row length
  `ASSERT_ALWAYS(a_count_bound, count <= CW'(CAPACITY), "occupancy above capacity")
  // occupied cells form an unbroken run from the front
  `ASSERT_ALWAYS(a_valid_prefix, ((valid_vec + CAPACITY'(1)) & valid_vec) == '0, "gap in row")
  // occupancy counter agrees with the cells
  `ASSERT_ALWAYS(a_count_match, $countones(valid_vec) == int'(count), "count mismatch")
  // the token walk ends after the last cell
  `ASSERT_NEXT(a_scan_end, (state == S_SCAN) && (scnt == IW'(CAPACITY - 1)), state == S_CHK, "walk overran")
  // a result appears only from the completion step
  `ASSERT_IMPLY(a_rsp_source, $rose(rsp_valid), $past(state) == S_DONE, "stray result")

endmodule

@@ design/spq_cell.sv @@
// one slot of the sorted row: holds an entry and trades it with its neighbours
// depends on spq_pkg
module spq_cell #(
  parameter int KEY_WIDTH      = spq_pkg::KEY_WIDTH_DEF,
  parameter int PRIORITY_WIDTH = spq_pkg::PRIO_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  spq_pkg::cell_op_t         op,
  input  logic [KEY_WIDTH-1:0]      new_key,
  input  logic [PRIORITY_WIDTH-1:0] new_prio,
  input  spq_pkg::link_t            left,
  input  logic [KEY_WIDTH-1:0]      left_key,
  input  logic [PRIORITY_WIDTH-1:0] left_prio,
  input  logic                      right_valid,
  input  logic [KEY_WIDTH-1:0]      right_key,
  input  logic [PRIORITY_WIDTH-1:0] right_prio,
  output spq_pkg::link_t            link,
  output logic [KEY_WIDTH-1:0]      key,
  output logic [PRIORITY_WIDTH-1:0] prio
);
  import spq_pkg::*;

  logic valid;
  logic tok;
  logic tokf;
  logic sh;
  logic match;
  logic stay;

  assign match = valid && (key == new_key);
  // entry keeps its slot on insert when it sorts at or before the new one
  assign stay  = valid && (prio <= new_prio);

  assign link.valid = valid;
  assign link.stay  = stay;
  assign link.tok   = tok;
  assign link.tokf  = tokf;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      tok   <= 1'b0;
      tokf  <= 1'b0;
      sh    <= 1'b0;
    end else begin
      tok <= (op == CELL_SCAN) ? left.tok : 1'b0;
      case (op)
        CELL_SCAN: begin
          // token passes once; remember whether this slot is at or past the hit
          if (left.tok) begin
            tokf <= left.tokf | match;
            sh   <= left.tokf | match;
          end
        end
        CELL_POP: valid <= right_valid;
        CELL_DEL: begin
          if (sh) valid <= right_valid;
        end
        CELL_INS: begin
          if (!stay) valid <= left.stay | left.valid;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      CELL_POP: begin
        key  <= right_key;
        prio <= right_prio;
      end
      CELL_DEL: begin
        if (sh) begin
          key  <= right_key;
          prio <= right_prio;
        end
      end
      CELL_INS: begin
        if (!stay) begin
          if (left.stay) begin
            key  <= new_key;
            prio <= new_prio;
          end else begin
            key  <= left_key;
            prio <= left_prio;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
